### hw/rtl/continuous_cellular_automaton_grid_assert.svh
// Assertion macros for the cellular automaton grid checker.
// Depends on nothing; taken in by the checker file through an include.
`ifndef CONTINUOUS_CELLULAR_AUTOMATON_GRID_ASSERT_SVH
`define CONTINUOUS_CELLULAR_AUTOMATON_GRID_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define CCAG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CCAG_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ccag_pkg.sv
// Shared types and codes for the continuous cellular automaton grid.
// Depends on nothing; used by the top level and the checker.
package ccag_pkg;

    localparam int GRID_SIZE_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 17;

    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_STEP    = 3'd2;
    localparam logic [2:0] OP_SAVE    = 3'd3;
    localparam logic [2:0] OP_RESTORE = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [1:0] AVG_PLAIN = 2'd1;
    localparam logic [1:0] AVG_ORTH  = 2'd2;

    localparam logic [2:0] FN_MUL   = 3'd0;
    localparam logic [2:0] FN_ADD   = 3'd1;
    localparam logic [2:0] FN_SPLIT = 3'd2;
    localparam logic [2:0] FN_TENT  = 3'd3;
    localparam logic [2:0] FN_RIGHT = 3'd4;
    localparam logic [2:0] FN_LEFT  = 3'd5;

    localparam logic [1:0] REG_CF   = 2'd0;
    localparam logic [1:0] REG_AVG  = 2'd1;
    localparam logic [1:0] REG_FUNC = 2'd2;
    localparam logic [1:0] REG_THR  = 2'd3;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [4:0]       row;
        logic [4:0]       col;
        logic [VAL_W-1:0] write_value;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
        logic             gate;
    } t_out;

endpackage

### hw/rtl/ccag_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ccag_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ccag_div.sv
// Shared restoring divider, one quotient bit a cycle; divisor zero gives zero.
// Depends on nothing.
module ccag_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNW-1:0]   r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic             r_dz;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_dz   <= (i_den == '0);
            end else if (r_busy) begin
                // shift in one numerator bit, subtract where it fits
                r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dz ? '0 : r_q;
endmodule

### hw/rtl/continuous_cellular_automaton_grid.sv
// Continuous cellular automaton on a toroidal grid: top level, sequencer and grids.
// Depends on ccag_pkg, ccag_ram and ccag_div.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//  config   | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// Save, restore: one copy sweep; write: the cell write, then a save copy sweep.
// Clear: a clearing pass. Step: a copy into the scratch grid, then per cell:
// eight neighbour reads from one RAM port, the average (a reciprocal multiply for
// the weighted mean) and the cell function, with one pass of the shared divide for
// the dividing functions.
// After reset a clearing pass zeroes the live and saved grids;
// the input channel is not ready until it ends, while config writes are taken.
// A result held on a stalled output does not stop the next word being accepted.
module continuous_cellular_automaton_grid
    import ccag_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW     = FRAC_BITS + 1;
    localparam int CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(GRID_SIZE);
    localparam int XW     = (CW > VAL_W) ? CW : VAL_W;
    localparam int SW     = FRAC_BITS + 3;
    localparam int TW     = FRAC_BITS + 5;
    localparam int NW     = 2 * FRAC_BITS + 1;
    localparam int PW     = 2 * FRAC_BITS + 7;
    localparam int R7_SH  = FRAC_BITS + 6;
    localparam longint R7_MUL = ((longint'(1) << R7_SH) + 6) / 7;
    localparam int CF_RST = (6 * (1 << FRAC_BITS) + 10) / 20;
    localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_COPY = 4'd3;
    localparam logic [3:0] S_NRD  = 4'd4;
    localparam logic [3:0] S_AVG  = 4'd5;
    localparam logic [3:0] S_AVGW = 4'd6;
    localparam logic [3:0] S_FN   = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_FNW  = 4'd9;
    localparam logic [3:0] S_CWR  = 4'd10;
    localparam logic [3:0] S_RD   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam logic [1:0] CP_SAVE = 2'd0;
    localparam logic [1:0] CP_REST = 2'd1;
    localparam logic [1:0] CP_SCR  = 2'd2;

    localparam logic [1:0] FM_VAL = 2'd0;
    localparam logic [1:0] FM_DIV = 2'd1;
    localparam logic [1:0] FM_MUL = 2'd2;

    // fold a five-bit address field onto the grid
    function automatic logic [RW-1:0] grid_mod(input logic [4:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < 8; i++) begin
            if (t >= 9'(GRID_SIZE)) begin
                t = t - 9'(GRID_SIZE);
            end
        end
        return RW'(t);
    endfunction

    // configuration registers
    logic [CW-1:0]    r_cf;
    logic [1:0]       r_avg;
    logic [2:0]       r_fsel;
    logic [VAL_W-1:0] r_thr;

    // sequencer state
    logic [3:0]    r_st;
    logic          r_boot;
    logic [1:0]    r_mode;
    logic [AW:0]   r_idx;
    logic          r_pv;
    logic [AW-1:0] r_pa;
    logic [AW-1:0] r_ta;
    logic [CW-1:0] r_wv;
    logic [RW-1:0] r_cr;
    logic [RW-1:0] r_cc;
    logic [AW-1:0] r_ca;
    logic [3:0]    r_k;
    logic          r_nv;
    logic          r_nd;
    logic [SW-1:0] r_orth;
    logic [SW-1:0] r_diag;
    logic [SW-1:0] r_y;
    logic [CW-1:0] r_a;
    logic [2*CW-1:0]      r_mul;
    logic [FRAC_BITS-1:0] r_v;
    logic          r_dstart;
    logic [NW-1:0] r_dnum;
    logic [CW-1:0] r_dden;
    logic          r_ovalid;
    t_out          r_out;

    // memory ports
    logic          live_we, sav_we, scr_we;
    logic [AW-1:0] live_wa, sav_wa, scr_wa;
    logic [CW-1:0] live_wd, sav_wd, scr_wd;
    logic [AW-1:0] live_ra, sav_ra, scr_ra;
    logic [CW-1:0] live_rd, sav_rd, scr_rd;
    logic [CW-1:0] src_rd;

    logic          div_done;
    logic [NW-1:0] div_q;

    logic [RW-1:0] up, dn, lf, rt, nr, nc;
    logic [AW-1:0] nb_addr;
    logic [RW-1:0] in_r, in_c;
    logic          in_acc;
    logic          out_free;

    logic [1:0]           fm;
    logic [CW-1:0]        fx, fd;
    logic [FRAC_BITS-1:0] fv;
    logic                 lt;
    logic [CW-1:0]        om_a, om_c;
    logic [TW-1:0]        wsum;

    ccag_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_live (
        .i_clk(i_clk), .i_we(live_we), .i_waddr(live_wa), .i_wdata(live_wd),
        .i_raddr(live_ra), .o_rdata(live_rd)
    );
    ccag_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_saved (
        .i_clk(i_clk), .i_we(sav_we), .i_waddr(sav_wa), .i_wdata(sav_wd),
        .i_raddr(sav_ra), .o_rdata(sav_rd)
    );
    ccag_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_scratch (
        .i_clk(i_clk), .i_we(scr_we), .i_waddr(scr_wa), .i_wdata(scr_wd),
        .i_raddr(scr_ra), .o_rdata(scr_rd)
    );

    ccag_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_dnum),
        .i_den(r_dden), .o_done(div_done), .o_quo(div_q)
    );

    // ---------------------------------------------------------------------
    // Configuration port: zero wait states, writes land on the access cycle.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf   <= CW'(CF_RST);
            r_avg  <= '0;
            r_fsel <= '0;
            r_thr  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_CF: begin
                    // saturate cf at one
                    r_cf <= (XW'(pwdata[VAL_W-1:0]) > XW'(ONE)) ? ONE
                                                                : CW'(pwdata[VAL_W-1:0]);
                end
                REG_AVG:  r_avg  <= pwdata[1:0];
                REG_FUNC: r_fsel <= pwdata[2:0];
                REG_THR:  r_thr  <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CF:   prdata = 32'(r_cf);
            REG_AVG:  prdata = 32'(r_avg);
            REG_FUNC: prdata = 32'(r_fsel);
            REG_THR:  prdata = 32'(r_thr);
            default:  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Neighbour addressing with toroidal wrap.
    // ---------------------------------------------------------------------
    always_comb begin
        up = (r_cr == '0) ? RW'(GRID_SIZE - 1) : r_cr - 1'b1;
        dn = (r_cr == RW'(GRID_SIZE - 1)) ? '0 : r_cr + 1'b1;
        lf = (r_cc == '0) ? RW'(GRID_SIZE - 1) : r_cc - 1'b1;
        rt = (r_cc == RW'(GRID_SIZE - 1)) ? '0 : r_cc + 1'b1;
        // orthogonal neighbours first, then the diagonals
        case (r_k[2:0])
            3'd0:    begin nr = r_cr; nc = lf;   end
            3'd1:    begin nr = up;   nc = r_cc; end
            3'd2:    begin nr = r_cr; nc = rt;   end
            3'd3:    begin nr = dn;   nc = r_cc; end
            3'd4:    begin nr = up;   nc = lf;   end
            3'd5:    begin nr = up;   nc = rt;   end
            3'd6:    begin nr = dn;   nc = rt;   end
            default: begin nr = dn;   nc = lf;   end
        endcase
        nb_addr = AW'(AW'(nr) * AW'(GRID_SIZE)) + AW'(nc);
    end

    // ---------------------------------------------------------------------
    // Memory port steering.
    // ---------------------------------------------------------------------
    assign src_rd = (r_mode == CP_REST) ? sav_rd : live_rd;

    always_comb begin
        live_we = 1'b0; live_wa = r_ta; live_wd = r_wv;   live_ra = r_ta;
        sav_we  = 1'b0; sav_wa  = r_pa; sav_wd  = src_rd; sav_ra  = r_idx[AW-1:0];
        scr_we  = 1'b0; scr_wa  = r_pa; scr_wd  = src_rd; scr_ra  = nb_addr;
        case (r_st)
            S_CLR: begin
                live_we = 1'b1; live_wa = r_idx[AW-1:0]; live_wd = '0;
                sav_we  = 1'b1; sav_wa  = r_idx[AW-1:0]; sav_wd  = '0;
            end
            S_WR: begin
                live_we = 1'b1;
            end
            S_COPY: begin
                live_ra = r_idx[AW-1:0];
                live_wa = r_pa;
                live_wd = src_rd;
                case (r_mode)
                    CP_REST: live_we = r_pv;
                    CP_SCR:  scr_we  = r_pv;
                    default: sav_we  = r_pv;
                endcase
            end
            S_CWR: begin
                live_we = 1'b1; live_wa = r_ca; live_wd = CW'(r_v);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Cell function: pick a direct value, a product, or a quotient.
    // ---------------------------------------------------------------------
    always_comb begin
        lt   = r_a < r_cf;
        om_a = ONE - r_a;
        om_c = ONE - r_cf;
        fm   = FM_VAL;
        fx   = r_a;
        fd   = r_cf;
        fv   = r_a[FRAC_BITS-1:0];
        case (r_fsel)
            FN_MUL: fm = FM_MUL;
            FN_ADD: fv = FRAC_BITS'(r_a + r_cf);
            FN_SPLIT: begin
                fm = FM_DIV;
                fd = lt ? r_cf : om_c;
            end
            FN_TENT: begin
                fm = FM_DIV;
                fx = lt ? r_a : om_a;
                fd = lt ? r_cf : om_c;
            end
            FN_RIGHT: begin
                fm = lt ? FM_VAL : FM_DIV;
                fx = om_a;
                fd = om_c;
                fv = '0;
            end
            FN_LEFT: begin
                fm = lt ? FM_DIV : FM_VAL;
                fv = '0;
            end
            default: ;
        endcase
    end

    assign wsum     = TW'(4 * TW'(r_orth)) + TW'(3 * TW'(r_diag));
    assign in_r     = grid_mod(i_in_data.row);
    assign in_c     = grid_mod(i_in_data.col);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_boot   <= 1'b1;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_nv     <= 1'b0;
            r_k      <= '0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_CLR: begin
                    if (r_idx[AW-1:0] == LAST) begin
                        r_idx  <= '0;
                        r_boot <= 1'b0;
                        r_st   <= r_boot ? S_IDLE : S_RD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_ta  <= AW'(AW'(in_r) * AW'(GRID_SIZE)) + AW'(in_c);
                        r_wv  <= (XW'(i_in_data.write_value) > XW'(ONE)) ? ONE
                                                       : CW'(i_in_data.write_value);
                        r_idx <= '0;
                        case (i_in_data.opcode)
                            OP_WRITE: r_st <= S_WR;
                            OP_STEP: begin
                                r_mode <= CP_SCR;
                                r_st   <= S_COPY;
                            end
                            OP_SAVE: begin
                                r_mode <= CP_SAVE;
                                r_st   <= S_COPY;
                            end
                            OP_RESTORE: begin
                                r_mode <= CP_REST;
                                r_st   <= S_COPY;
                            end
                            OP_CLEAR: r_st <= S_CLR;
                            default:  r_st <= S_RD;
                        endcase
                    end
                end
                S_WR: begin
                    // the write then snapshots the grid
                    r_mode <= CP_SAVE;
                    r_idx  <= '0;
                    r_st   <= S_COPY;
                end
                S_COPY: begin
                    r_pa <= r_idx[AW-1:0];
                    r_pv <= (r_idx != (AW+1)'(CELLS));
                    if (r_idx != (AW+1)'(CELLS)) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        if (r_mode == CP_SCR) begin
                            r_cr   <= '0;
                            r_cc   <= '0;
                            r_ca   <= '0;
                            r_k    <= '0;
                            r_orth <= '0;
                            r_diag <= '0;
                            r_st   <= S_NRD;
                        end else begin
                            r_st <= S_RD;
                        end
                    end
                end
                S_NRD: begin
                    // issue one neighbour read a cycle, accumulate it in the next cycle
                    r_nv <= (r_k != 4'd8);
                    r_nd <= r_k[2];
                    if (r_k != 4'd8) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_st <= S_AVG;
                    end
                    if (r_nv) begin
                        if (r_nd) begin
                            r_diag <= r_diag + SW'(scr_rd);
                        end else begin
                            r_orth <= r_orth + SW'(scr_rd);
                        end
                    end
                end
                S_AVG: begin
                    r_nv <= 1'b0;
                    case (r_avg)
                        AVG_PLAIN: begin
                            r_a  <= CW'(((SW+1)'(r_orth) + (SW+1)'(r_diag)) >> 3);
                            r_st <= S_FN;
                        end
                        AVG_ORTH: begin
                            r_a  <= CW'(r_orth >> 2);
                            r_st <= S_FN;
                        end
                        default: begin
                            // weighted mean over 28: take the quarter here
                            r_y  <= SW'(wsum >> 2);
                            r_st <= S_AVGW;
                        end
                    endcase
                end
                S_AVGW: begin
                    // divide the quarter by seven with a reciprocal multiply
                    r_a  <= CW'((PW'(r_y) * PW'(R7_MUL)) >> R7_SH);
                    r_st <= S_FN;
                end
                S_FN: begin
                    case (fm)
                        FM_MUL: begin
                            r_mul <= r_a * r_cf;
                            r_st  <= S_MUL;
                        end
                        FM_DIV: begin
                            r_dnum   <= NW'(fx) << FRAC_BITS;
                            r_dden   <= fd;
                            r_dstart <= 1'b1;
                            r_st     <= S_FNW;
                        end
                        default: begin
                            r_v  <= fv;
                            r_st <= S_CWR;
                        end
                    endcase
                end
                S_MUL: begin
                    r_v  <= FRAC_BITS'(r_a + CW'(r_mul >> FRAC_BITS));
                    r_st <= S_CWR;
                end
                S_FNW: begin
                    if (div_done) begin
                        r_v  <= div_q[FRAC_BITS-1:0];
                        r_st <= S_CWR;
                    end
                end
                S_CWR: begin
                    // advance to the next cell in raster order
                    r_ca   <= r_ca + 1'b1;
                    r_k    <= '0;
                    r_orth <= '0;
                    r_diag <= '0;
                    if (r_cc == RW'(GRID_SIZE - 1)) begin
                        r_cc <= '0;
                        r_cr <= r_cr + 1'b1;
                    end else begin
                        r_cc <= r_cc + 1'b1;
                    end
                    r_st <= (r_ca == LAST) ? S_RD : S_NRD;
                end
                S_RD: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out.cell_value <= VAL_W'(live_rd);
                        r_out.gate       <= XW'(live_rd) > XW'(r_thr);
                        r_ovalid         <= 1'b1;
                        r_st             <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

### hw/rtl/ccag_checker.sv
// Port-level checker for the cellular automaton grid, bound to the top level.
// Depends on ccag_pkg and continuous_cellular_automaton_grid_assert.svh.
`include "continuous_cellular_automaton_grid_assert.svh"

module ccag_checker
    import ccag_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);
    `CCAG_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result word dropped while stalled")
    `CCAG_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data), "stalled result word changed")
    `CCAG_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready after an accepted word")
    `CCAG_ASSERT(a_gate_nonzero, i_clk, i_rst_n, o_out_valid && o_out_data.gate |-> o_out_data.cell_value != '0, "gate set on an empty cell")
    `CCAG_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid && !o_in_ready, "outputs active after reset")
endmodule

bind continuous_cellular_automaton_grid ccag_checker u_ccag_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data(o_out_data)
);
